// ===== hw/rtl/mcr_pkg.sv =====
`default_nettype none
package mcr_pkg;

	// default geometry
	localparam int COORD_WIDTH_DEF  = 10;
	localparam int RADIUS_WIDTH_DEF = 9;

	// step records buffered between front and back
	localparam int QUEUE_DEPTH = 2;

	// input kinds carried on s_tuser
	localparam logic ACT_START = 1'b0;
	localparam logic ACT_STEP  = 1'b1;

	// decision value arithmetic
	localparam int DEC_INIT    = 3;
	localparam int DEC_INC_NEG = 6;
	localparam int DEC_INC_POS = 10;

	// mirror index: bit 2 swaps x/y, bit 1 negates the row term, bit 0 the column term
	localparam logic [2:0] FIRST_MIRROR = 3'd0;
	localparam logic [2:0] LAST_MIRROR  = 3'd7;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/mcr_queue.sv =====
`default_nettype none
module mcr_queue
	import mcr_pkg::*;
#(
	parameter int WIDTH = 8,
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	input  logic             pop,
	output logic [WIDTH-1:0] head_data,
	output q_stat_t          stat
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign stat.full  = (count_q == CNT_FULL);
	assign stat.empty = (count_q == '0);
	assign head_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!stat.full || pop))
		else $error("queue push while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !stat.empty)
		else $error("queue pop while empty");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

endmodule
`default_nettype wire

// ===== hw/rtl/mcr_front.sv =====
`default_nettype none
module mcr_front
	import mcr_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF,
	parameter int JOB_W        = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 1) + 1
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    accept,
	input  logic                    action,
	input  logic [COORD_WIDTH-1:0]  center_x,
	input  logic [COORD_WIDTH-1:0]  center_y,
	input  logic [RADIUS_WIDTH-1:0] radius,
	output logic                    push,
	output logic [JOB_W-1:0]        push_data
);

	localparam int OFS_W = RADIUS_WIDTH + 1;
	localparam int DEC_W = RADIUS_WIDTH + 4;
	localparam int CMP_W = OFS_W + 1;

	logic [OFS_W-1:0]       ofs_x_q;
	logic [OFS_W-1:0]       ofs_y_q;
	logic [DEC_W-1:0]       dec_q;
	logic [COORD_WIDTH-1:0] cx_q;
	logic [COORD_WIDTH-1:0] cy_q;
	logic                   busy_q;

	logic             dec_neg;
	logic [DEC_W-1:0] x_times4;
	logic [DEC_W-1:0] diff_times4;
	logic [DEC_W-1:0] dec_nxt;
	logic [DEC_W-1:0] dec_init;
	logic [CMP_W-1:0] nx_w;
	logic [CMP_W-1:0] ny_w;
	logic             done;
	logic             start;

	assign start   = accept && (action == ACT_START);
	assign push    = accept && (action == ACT_STEP) && busy_q;
	assign dec_neg = dec_q[DEC_W-1];

	always_comb begin
		x_times4    = DEC_W'({ofs_x_q, 2'b00});
		diff_times4 = (DEC_W'(ofs_x_q) - DEC_W'(ofs_y_q)) << 2;
		dec_nxt     = dec_neg ? dec_q + x_times4 + DEC_W'(DEC_INC_NEG)
		                      : dec_q + diff_times4 + DEC_W'(DEC_INC_POS);
		dec_init    = DEC_W'(DEC_INIT) - DEC_W'({radius, 1'b0});
		nx_w        = {1'b0, ofs_x_q} + CMP_W'(1);
		ny_w        = dec_neg ? {1'b0, ofs_y_q} : {1'b0, ofs_y_q} - CMP_W'(1);
		done        = $signed(nx_w) > $signed(ny_w);
	end

	// current offsets go out; the update applies to the following step
	assign push_data = {done, ofs_y_q, ofs_x_q, cy_q, cx_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (push && done) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			cx_q    <= center_x;
			cy_q    <= center_y;
			ofs_x_q <= '0;
			ofs_y_q <= OFS_W'(radius);
			dec_q   <= dec_init;
		end else if (push) begin
			ofs_x_q <= nx_w[OFS_W-1:0];
			ofs_y_q <= ny_w[OFS_W-1:0];
			dec_q   <= dec_nxt;
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/mcr_back.sv =====
`default_nettype none
module mcr_back
	import mcr_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF,
	parameter int JOB_W        = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 1) + 1
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  q_stat_t                  q_stat,
	input  logic [JOB_W-1:0]         head_data,
	output logic                     pop,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [COORD_WIDTH+1:0]   pixel_x,
	output logic [COORD_WIDTH+1:0]   pixel_y,
	output logic                     last_of_step,
	output logic                     circle_done
);

	localparam int OFS_W = RADIUS_WIDTH + 1;
	localparam int PIX_W = COORD_WIDTH + 2;
	localparam int CY_LO = COORD_WIDTH;
	localparam int X_LO  = 2 * COORD_WIDTH;
	localparam int Y_LO  = X_LO + OFS_W;

	logic [COORD_WIDTH-1:0] cx;
	logic [COORD_WIDTH-1:0] cy;
	logic [OFS_W-1:0]       ofs_x;
	logic [OFS_W-1:0]       ofs_y;
	logic [OFS_W-1:0]       col_ofs;
	logic [OFS_W-1:0]       row_ofs;
	logic [PIX_W-1:0]       px;
	logic [PIX_W-1:0]       py;
	logic                   load;

	logic [2:0]       idx_q;
	logic             out_valid_q;
	logic [PIX_W-1:0] px_q;
	logic [PIX_W-1:0] py_q;
	logic             last_q;
	logic             done_q;

	assign cx    = head_data[CY_LO-1:0];
	assign cy    = head_data[X_LO-1:CY_LO];
	assign ofs_x = head_data[Y_LO-1:X_LO];
	assign ofs_y = head_data[Y_LO+OFS_W-1:Y_LO];

	always_comb begin
		col_ofs = idx_q[2] ? ofs_y : ofs_x;
		row_ofs = idx_q[2] ? ofs_x : ofs_y;
		px = idx_q[0] ? PIX_W'(cx) - PIX_W'(col_ofs) : PIX_W'(cx) + PIX_W'(col_ofs);
		py = idx_q[1] ? PIX_W'(cy) - PIX_W'(row_ofs) : PIX_W'(cy) + PIX_W'(row_ofs);
	end

	// advance one mirror per cycle whenever a step is queued and the output register frees up
	assign load = !q_stat.empty && (!out_valid_q || out_ready);
	assign pop  = load && (idx_q == LAST_MIRROR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= FIRST_MIRROR;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			px_q   <= px;
			py_q   <= py;
			last_q <= (idx_q == LAST_MIRROR);
			done_q <= head_data[JOB_W-1];
		end
	end

	assign out_valid    = out_valid_q;
	assign pixel_x      = px_q;
	assign pixel_y      = py_q;
	assign last_of_step = last_q;
	assign circle_done  = done_q;

	a_pop_rewinds: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (idx_q == FIRST_MIRROR))
		else $error("mirror index did not rewind after a step");

	a_pop_marks_last: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (out_valid && last_of_step))
		else $error("step retired without a marked last pixel");

	a_last_at_rewind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last_of_step) |-> (idx_q == FIRST_MIRROR))
		else $error("last pixel shown mid-step");

endmodule
`default_nettype wire

// ===== hw/rtl/midpoint_circle_rasterizer_top.sv =====
// Channel | Dir | tdata (low bit up)                   | tuser     | tlast
// s_*     | in  | center_x, center_y, radius, zero pad | action    | -
// m_*     | out | pixel_x, pixel_y                     | circle_done | last_of_step
//
// One transaction in per cycle while the step queue has room; a start transaction
// loads the circle and emits nothing, a step transaction while a circle is active
// yields eight pixel transactions, one per cycle while m_tready stays high, through
// the single pixel output register; the step leaves the queue as its last pixel loads.
// Reset (arst_n low) clears the queue and goes idle; a stalled m_tready holds the
// output register and fills the queue, after which s_tready drops.
`default_nettype none
module midpoint_circle_rasterizer_top
	import mcr_pkg::*;
#(
	parameter int COORD_WIDTH  = COORD_WIDTH_DEF,
	parameter int RADIUS_WIDTH = RADIUS_WIDTH_DEF,
	parameter int S_TDATA_W    = ((2 * COORD_WIDTH + RADIUS_WIDTH + 7) / 8) * 8,
	parameter int M_TDATA_W    = ((2 * (COORD_WIDTH + 2) + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // center_x, center_y, radius, zero pad
	input  logic                 s_tuser,   // action
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // pixel_x, pixel_y, zero pad
	output logic                 m_tuser,   // circle_done
	output logic                 m_tlast    // last_of_step
);

	localparam int JOB_W = 2 * COORD_WIDTH + 2 * (RADIUS_WIDTH + 1) + 1;
	localparam int PIX_W = COORD_WIDTH + 2;

	q_stat_t          q_stat;
	logic             accept;
	logic             push;
	logic [JOB_W-1:0] push_data;
	logic             pop;
	logic [JOB_W-1:0] head_data;
	logic [PIX_W-1:0] pixel_x;
	logic [PIX_W-1:0] pixel_y;

	// hold off new transactions only while the step queue is full
	assign s_tready = !q_stat.full;
	assign accept   = s_tvalid && s_tready;

	// front: decode the transaction, run the midpoint recurrence, queue each step
	mcr_front #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH),
		.JOB_W       (JOB_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.action   (s_tuser),
		.center_x (s_tdata[COORD_WIDTH-1:0]),
		.center_y (s_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
		.radius   (s_tdata[2*COORD_WIDTH+RADIUS_WIDTH-1:2*COORD_WIDTH]),
		.push     (push),
		.push_data(push_data)
	);

	// queue: decouple step generation from pixel emission
	mcr_queue #(
		.WIDTH(JOB_W),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.head_data(head_data),
		.stat     (q_stat)
	);

	// back: expand each queued step into its eight mirrored pixels
	mcr_back #(
		.COORD_WIDTH (COORD_WIDTH),
		.RADIUS_WIDTH(RADIUS_WIDTH),
		.JOB_W       (JOB_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_stat      (q_stat),
		.head_data   (head_data),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.pixel_x     (pixel_x),
		.pixel_y     (pixel_y),
		.last_of_step(m_tlast),
		.circle_done (m_tuser)
	);

	assign m_tdata = M_TDATA_W'({pixel_y, pixel_x});

endmodule
`default_nettype wire

// ===== bench/testbench.sv =====
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mcr_pkg::*;

	localparam int CW          = COORD_WIDTH_DEF;
	localparam int RW          = RADIUS_WIDTH_DEF;
	localparam int PW          = CW + 2;
	localparam int S_W         = ((2 * CW + RW + 7) / 8) * 8;
	localparam int M_W         = ((2 * PW + 7) / 8) * 8;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_WAIT  = 16;
	localparam int CYCLE_LIMIT = 300000;

	// one input transaction: kind plus the three start fields
	typedef struct packed {
		logic          action;
		logic [CW-1:0] cx;
		logic [CW-1:0] cy;
		logic [RW-1:0] r;
	} circle_cmd_t;

	// one pixel transaction as it should leave the block
	typedef struct packed {
		logic [PW-1:0] col;
		logic [PW-1:0] row;
		logic          last;
		logic          done;
	} pixel_t;

	logic           clk      = 1'b0;
	logic           arst_n   = 1'b0;
	logic           s_tvalid = 1'b0;
	logic           s_tready;
	logic [S_W-1:0] s_tdata  = '0;
	logic           s_tuser  = ACT_START;
	logic           m_tvalid;
	logic           m_tready = 1'b0;
	logic [M_W-1:0] m_tdata;
	logic           m_tuser;
	logic           m_tlast;

	midpoint_circle_rasterizer_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// commands waiting for the driver, pixels waiting for the output side
	circle_cmd_t pending_cmds[$];
	pixel_t      due_pixels[$];

	// knobs set per phase by the stimulus process
	int send_gap_pct   = 0;
	int sink_stall_pct = 0;
	int hold_req       = 0;
	int hold_seen      = 0;
	int hold_left      = 0;

	int   errors      = 0;
	int   cycle_count = 0;
	logic in_fire     = 1'b0;

	// shadow copy of the rasterizer state
	logic [RW:0]   ofs_x    = '0;
	logic [RW:0]   ofs_y    = '0;
	logic [RW+3:0] dec_val  = '0;
	logic [CW-1:0] ctr_col  = '0;
	logic [CW-1:0] ctr_row  = '0;
	logic          drawing  = 1'b0;

	function automatic logic [PW-1:0] wrap_pix(input int v);
		logic [31:0] b;
		b = v;
		return b[PW-1:0];
	endfunction

	// Advance the shadow rasterizer by one accepted command and queue the pixels it owes.
	task automatic rasterize_cmd(input circle_cmd_t c);
		int     x, y, d, nx, ny, a, b, rr;
		logic   fin;
		pixel_t p;
		if (c.action == ACT_START) begin
			rr      = c.r;
			ctr_col = c.cx;
			ctr_row = c.cy;
			ofs_x   = '0;
			ofs_y   = {1'b0, c.r};
			d       = DEC_INIT - 2 * rr;
			dec_val = d[RW+3:0];
			drawing = 1'b1;
		end else if (drawing) begin
			x = ofs_x;
			y = ofs_y;
			d = $signed(dec_val);
			// a negative decision keeps the row, otherwise step inward
			if (d < 0) begin
				d  = d + 4 * x + DEC_INC_NEG;
				ny = y;
			end else begin
				d  = d + 4 * (x - y) + DEC_INC_POS;
				ny = y - 1;
			end
			nx  = x + 1;
			fin = (nx > ny);
			// octant order: bit 2 swaps the offsets, bit 0 negates column, bit 1 row
			for (int k = 0; k < 8; k++) begin
				a      = (k & 4) ? y : x;
				b      = (k & 4) ? x : y;
				p.col  = wrap_pix(int'(ctr_col) + ((k & 1) ? -a : a));
				p.row  = wrap_pix(int'(ctr_row) + ((k & 2) ? -b : b));
				p.last = (k == 7);
				p.done = fin;
				due_pixels.push_back(p);
			end
			dec_val = d[RW+3:0];
			ofs_x   = nx[RW:0];
			ofs_y   = ny[RW:0];
			if (fin)
				drawing = 1'b0;
		end
	endtask

	task automatic push_cmd(input logic act, input int cx, input int cy, input int r);
		circle_cmd_t c;
		c.action = act;
		c.cx     = cx[CW-1:0];
		c.cy     = cy[CW-1:0];
		c.r      = r[RW-1:0];
		pending_cmds.push_back(c);
	endtask

	// Step transactions carry random payload, which the block must ignore.
	task automatic push_step();
		push_cmd(ACT_STEP, $urandom_range(1023), $urandom_range(1023), $urandom_range(511));
	endtask

	task automatic push_steps(input int n);
		repeat (n) push_step();
	endtask

	// Mostly complete circles with random geometry, some abandoned early, plus loose noise.
	task automatic queue_random(input int count);
		int made, r, n;
		made = 0;
		while (made < count) begin
			if ($urandom_range(99) < 85) begin
				if ($urandom_range(99) < 80)
					r = $urandom_range(24);
				else
					r = $urandom_range(511);
				push_cmd(ACT_START, $urandom_range(1023), $urandom_range(1023), r);
				if (r > 24)
					n = $urandom_range(1, 12);
				else if ($urandom_range(3) != 0)
					n = (r * 3) / 4 + 1;
				else
					n = $urandom_range(1, r / 2 + 1);
				push_steps(n);
				made += n + 1;
			end else begin
				push_cmd(1'($urandom_range(1)), $urandom_range(1023), $urandom_range(1023),
					$urandom_range(511));
				made++;
			end
		end
	endtask

	// Hold until every command has been taken and every owed pixel has come out.
	task automatic drain();
		while (pending_cmds.size() != 0 || s_tvalid || due_pixels.size() != 0)
			@(posedge clk);
	endtask

	// Driver: hold a transaction until it is taken, then offer the next one or idle.
	always @(negedge clk) begin : drive_input
		circle_cmd_t c;
		logic [S_W-1:0] word;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || in_fire) begin
			if (pending_cmds.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
				c    = pending_cmds.pop_front();
				word = '0;
				word[CW-1:0]          = c.cx;
				word[2*CW-1:CW]       = c.cy;
				word[2*CW+RW-1:2*CW]  = c.r;
				s_tvalid <= 1'b1;
				s_tdata  <= word;
				s_tuser  <= c.action;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// Sink: a requested hold-off wins over random stalls; keep one assignment per edge.
	always @(negedge clk) begin : drive_ready
		logic rdy;
		rdy = 1'b1;
		if (hold_left != 0) begin
			rdy = 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			rdy = 1'b0;
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else if ($urandom_range(99) < sink_stall_pct) begin
			rdy = 1'b0;
		end
		m_tready <= rdy;
	end

	// Monitor: predict on every accepted command, check every accepted pixel.
	always @(posedge clk) begin : watch
		circle_cmd_t c;
		pixel_t      want, got;
		if (!arst_n) begin
			in_fire <= 1'b0;
		end else begin
			in_fire <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) begin
				c.action = s_tuser;
				c.cx     = s_tdata[CW-1:0];
				c.cy     = s_tdata[2*CW-1:CW];
				c.r      = s_tdata[2*CW+RW-1:2*CW];
				rasterize_cmd(c);
			end
			if (m_tvalid && m_tready) begin
				got.col  = m_tdata[PW-1:0];
				got.row  = m_tdata[2*PW-1:PW];
				got.last = m_tlast;
				got.done = m_tuser;
				if (due_pixels.size() == 0) begin
					$display("%0t: unexpected pixel col=%0d row=%0d last=%b done=%b",
						$time, $signed(got.col), $signed(got.row), got.last, got.done);
					errors++;
				end else begin
					want = due_pixels.pop_front();
					if (got.col !== want.col) begin
						$display("%0t: pixel_x expected %0d got %0d", $time,
							$signed(want.col), $signed(got.col));
						errors++;
					end
					if (got.row !== want.row) begin
						$display("%0t: pixel_y expected %0d got %0d", $time,
							$signed(want.row), $signed(got.row));
						errors++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last_of_step expected %b got %b", $time,
							want.last, got.last);
						errors++;
					end
					if (got.done !== want.done) begin
						$display("%0t: circle_done expected %b got %b", $time,
							want.done, got.done);
						errors++;
					end
				end
			end
		end
	end

	// Watchdog: stop a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL midpoint_circle_rasterizer_top");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: step while idle, zero radius at the origin,
		// largest circle at the far corner, restart while busy, finish then idle step,
		// large radius at the origin (wraps negative), and a small circle run past its end.
		push_step();
		push_cmd(ACT_START, 0, 0, 0);
		push_step();
		push_step();
		push_cmd(ACT_START, 1023, 1023, 511);
		push_steps(3);
		push_cmd(ACT_START, 1023, 0, 1);
		push_steps(2);
		push_cmd(ACT_START, 0, 1023, 2);
		push_steps(3);
		push_cmd(ACT_START, 0, 0, 511);
		push_steps(2);
		push_cmd(ACT_START, 512, 300, 3);
		push_steps(4);
		drain();

		// Phase with no idling; the sink holds off long enough to back the block up.
		send_gap_pct   = 0;
		sink_stall_pct = 0;
		hold_req       = hold_req + 1;
		queue_random(85);
		drain();

		// Sender idles about half the time.
		send_gap_pct = 49;
		queue_random(85);
		drain();

		// Receiver stalls about half the time.
		send_gap_pct   = 0;
		sink_stall_pct = 49;
		queue_random(85);
		drain();

		// Both sides idle.
		send_gap_pct   = 29;
		sink_stall_pct = 29;
		queue_random(85);
		drain();

		// Let any stray trailing pixel show up before the verdict.
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("PASS midpoint_circle_rasterizer_top");
		else
			$display("FAIL midpoint_circle_rasterizer_top");
		$finish;
	end

endmodule
`default_nettype wire
